[rtl/htw_pkg.sv]
// ----------------------------------------------------------------------------
// htw_pkg
// Types and codes shared by the timing wheel modules.
// ----------------------------------------------------------------------------
`default_nettype none
package htw_pkg;
    localparam int DVD_W  = 32;
    localparam int IDX_W  = 6;
    localparam int SEQ_W  = 16;
    localparam int SLOT_W = 16;
    localparam int ROT_W  = 20;
    localparam int CNT_W  = 7;

    localparam logic [ROT_W-1:0] ROT_MAX = '1;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic [DVD_W-1:0]  interval;
        logic [ROT_W-1:0]  rot;
        logic [SEQ_W-1:0]  seq;
        logic [SLOT_W-1:0] slot;
    } t_ent;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [IDX_W-1:0] idx;
        logic [SEQ_W-1:0] seq;
        logic [CNT_W-1:0] live;
        logic             last;
    } t_res;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
    } t_div_req;
endpackage
`default_nettype wire

[rtl/htw_div.sv]
// ----------------------------------------------------------------------------
// htw_div
// Divider by the wheel size through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module htw_div
    import htw_pkg::*;
#(
    parameter int WHEEL_SIZE = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_req          i_req,
    output logic                   o_done,
    output logic [DVD_W-1:0]       o_quot,
    output logic [SLOT_W-1:0]      o_rem
);
    localparam int RW = $clog2(WHEEL_SIZE);
    // floor(2^(32+RW) / WHEEL_SIZE) + 1 gives an exact quotient for 32-bit inputs
    localparam logic [63:0]    MAG_FULL = ((64'd1 << (DVD_W + RW)) / 64'(WHEEL_SIZE)) + 64'd1;
    localparam logic [DVD_W:0] MAGIC    = MAG_FULL[DVD_W:0];

    logic                r_ld;
    logic                r_mul;
    logic                r_done;
    logic [DVD_W-1:0]    r_x;
    logic [2*DVD_W:0]    r_prod;
    logic [RW-1:0]       r_rem;
    logic [DVD_W-1:0]    w_quot;
    logic [DVD_W-1:0]    w_diff;

    assign w_quot = DVD_W'(r_prod[2*DVD_W:DVD_W+RW]);
    assign w_diff = r_x - w_quot * DVD_W'(WHEEL_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld   <= 1'b0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ld   <= i_req.start;
            r_mul  <= r_ld;
            r_done <= r_mul;
        end
        if (i_req.start) begin
            r_x <= i_req.dividend;
        end
        if (r_ld) begin
            r_prod <= (2*DVD_W+1)'(r_x) * (2*DVD_W+1)'(MAGIC);
        end
        if (r_mul) begin
            r_rem <= w_diff[RW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = w_quot;
    assign o_rem  = SLOT_W'(r_rem);
endmodule
`default_nettype wire

[rtl/hashed_timing_wheel.sv]
// ----------------------------------------------------------------------------
// hashed_timing_wheel
// Timer table with wheel slots and rotation counts, one shared divider.
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                          tuser     tlast
// s_axis   in   expire_tick, interval_ticks, handle_index,  req_type  -
//               handle_seq
// m_axis   out  status, timer_index, timer_seq,             kind      last
//               active_count
// Add: lowest-free search over the entries, then two divider passes for
// rotation count and slot; a full table replies full. Cancel: read and
// check the entry, or reply stale for an index past the table. Tick: divide
// the new tick for the slot and scan every entry, re-arming periodic timers.
// Not ready until the item is done; a full output register stalls the
// sequencer. Reset is synchronous and clears the table at once.
`default_nettype none
module hashed_timing_wheel
    import htw_pkg::*;
#(
    parameter int WHEEL_SIZE = 4096,
    parameter int MAX_TIMERS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,  // expire_tick, interval_ticks, handle_index, handle_seq
    input  wire logic [1:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // status, timer_index, timer_seq, active_count
    output logic [1:0]       m_axis_tuser,  // kind
    output logic             m_axis_tlast
);
    localparam int IW = $clog2(MAX_TIMERS);

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_ASRCH   = 15'h0002,
        S_PLA     = 15'h0004,
        S_PLAW    = 15'h0008,
        S_PLBW    = 15'h0010,
        S_ADONE   = 15'h0020,
        S_CRD     = 15'h0040,
        S_CCHK    = 15'h0080,
        S_TDIV    = 15'h0100,
        S_TRD     = 15'h0200,
        S_TEX     = 15'h0400,
        S_TARM    = 15'h0800,
        S_TFIRE   = 15'h1000,
        S_TEND    = 15'h2000,
        S_REPLY   = 15'h4000
    } t_state;

    t_state r_state, n_state;

    logic [DVD_W-1:0]      w_expire, w_interval;
    logic [IDX_W-1:0]      w_hidx;
    logic [SEQ_W-1:0]      w_hseq;

    assign w_expire   = s_axis_tdata[31:0];
    assign w_interval = s_axis_tdata[63:32];
    assign w_hidx     = s_axis_tdata[69:64];
    assign w_hseq     = s_axis_tdata[85:70];

    logic [DVD_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]      r_live, n_live;
    logic [MAX_TIMERS-1:0] r_valid, n_valid;
    logic [MAX_TIMERS-1:0] r_canc, n_canc;
    logic [MAX_TIMERS-1:0] r_wr, n_wr;
    logic [IW:0]           r_i, n_i;
    logic [IW-1:0]         w_idx;
    logic [DVD_W-1:0]      r_delay, n_delay;
    logic [DVD_W-1:0]      r_intv, n_intv;
    logic [ROT_W-1:0]      r_rot, n_rot;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [SLOT_W-1:0]     r_tslot, n_tslot;
    logic                  r_pl_tick, n_pl_tick;
    logic [IDX_W-1:0]      r_hidx, n_hidx;
    logic [SEQ_W-1:0]      r_hseq, n_hseq;
    t_res                  r_res, n_res;
    logic [IDX_W-1:0]      r_fidx, n_fidx;
    logic [SEQ_W-1:0]      r_fseq, n_fseq;
    logic                  r_pv, n_pv;
    t_res                  r_pend, n_pend;
    logic                  r_ov, n_ov;
    t_res                  r_out, n_out;

    t_ent                  r_mem [MAX_TIMERS];
    t_ent                  r_rd;
    logic                  r_rd_wr;
    logic                  w_we;
    t_ent                  w_wdata;
    logic [SEQ_W-1:0]      w_eseq;

    t_div_req              w_div;
    logic                  w_ddone;
    logic [DVD_W-1:0]      w_quot;
    logic [SLOT_W-1:0]     w_rem;
    logic                  w_ofree;

    assign w_idx  = r_i[IW-1:0];
    assign w_eseq = r_rd_wr ? r_rd.seq : '0;
    assign w_ofree = !r_ov || m_axis_tready;

    htw_div #(.WHEEL_SIZE(WHEEL_SIZE)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_done  (w_ddone),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_idx] <= w_wdata;
        end
        r_rd    <= r_mem[w_idx];
        r_rd_wr <= r_wr[w_idx];
    end

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_live    = r_live;
        n_valid   = r_valid;
        n_canc    = r_canc;
        n_wr      = r_wr;
        n_i       = r_i;
        n_delay   = r_delay;
        n_intv    = r_intv;
        n_rot     = r_rot;
        n_slot    = r_slot;
        n_tslot   = r_tslot;
        n_pl_tick = r_pl_tick;
        n_hidx    = r_hidx;
        n_hseq    = r_hseq;
        n_res     = r_res;
        n_fidx    = r_fidx;
        n_fseq    = r_fseq;
        n_pv      = r_pv;
        n_pend    = r_pend;
        n_ov      = r_ov && !m_axis_tready;
        n_out     = r_out;
        w_we      = 1'b0;
        w_wdata   = r_rd;
        w_div     = '0;
        s_axis_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_hidx = w_hidx;
                    n_hseq = w_hseq;
                    case (s_axis_tuser)
                        REQ_ADD: begin
                            n_i     = '0;
                            n_intv  = w_interval;
                            n_delay = (w_expire > r_cur) ? w_expire - r_cur : DVD_W'(1);
                            n_state = S_ASRCH;
                        end
                        REQ_CANCEL: begin
                            if (32'(w_hidx) >= MAX_TIMERS) begin
                                n_res   = '{KIND_CANCEL, ST_STALE, w_hidx, w_hseq, r_live, 1'b1};
                                n_state = S_REPLY;
                            end else begin
                                n_i     = (IW+1)'(w_hidx);
                                n_state = S_CRD;
                            end
                        end
                        REQ_TICK: begin
                            n_cur          = r_cur + 1'b1;
                            w_div.start    = 1'b1;
                            w_div.dividend = r_cur + 1'b1;
                            n_state        = S_TDIV;
                        end
                        default: ;
                    endcase
                end
            end
            S_ASRCH: begin
                if (r_i == (IW+1)'(MAX_TIMERS)) begin
                    n_res   = '{KIND_ADD, ST_FULL, '0, '0, r_live, 1'b1};
                    n_state = S_REPLY;
                end else if (!r_valid[w_idx]) begin
                    n_pl_tick = 1'b0;
                    n_state   = S_PLA;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_PLA: begin
                w_div.start    = 1'b1;
                w_div.dividend = r_delay - 1'b1;
                n_state        = S_PLAW;
            end
            S_PLAW: begin
                if (w_ddone) begin
                    n_rot          = (w_quot > DVD_W'(ROT_MAX)) ? ROT_MAX : w_quot[ROT_W-1:0];
                    w_div.start    = 1'b1;
                    w_div.dividend = r_cur + r_delay;
                    n_state        = S_PLBW;
                end
            end
            S_PLBW: begin
                if (w_ddone) begin
                    n_slot  = w_rem;
                    n_state = r_pl_tick ? S_TARM : S_ADONE;
                end
            end
            S_ADONE: begin
                w_we           = 1'b1;
                w_wdata        = '{r_intv, r_rot, w_eseq, r_slot};
                n_valid[w_idx] = 1'b1;
                n_canc[w_idx]  = 1'b0;
                n_wr[w_idx]    = 1'b1;
                n_live         = r_live + 1'b1;
                n_res          = '{KIND_ADD, ST_OK, IDX_W'(w_idx), w_eseq, r_live + 1'b1, 1'b1};
                n_state        = S_REPLY;
            end
            S_CRD: begin
                n_state = S_CCHK;
            end
            S_CCHK: begin
                if (r_valid[w_idx] && w_eseq == r_hseq) begin
                    n_canc[w_idx] = 1'b1;
                    n_res = '{KIND_CANCEL, ST_OK, r_hidx, r_hseq, r_live, 1'b1};
                end else begin
                    n_res = '{KIND_CANCEL, ST_STALE, r_hidx, r_hseq, r_live, 1'b1};
                end
                n_state = S_REPLY;
            end
            S_TDIV: begin
                if (w_ddone) begin
                    n_tslot = w_rem;
                    n_i     = '0;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                n_state = S_TEX;
            end
            S_TEX: begin
                if (r_i == (IW+1)'(MAX_TIMERS)) begin
                    n_state = S_TEND;
                end else if (!r_valid[w_idx] || r_rd.slot != r_tslot) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_TRD;
                end else if (r_canc[w_idx]) begin
                    w_we           = 1'b1;
                    w_wdata.seq    = w_eseq + 1'b1;
                    n_wr[w_idx]    = 1'b1;
                    n_valid[w_idx] = 1'b0;
                    n_canc[w_idx]  = 1'b0;
                    if (r_live != '0) n_live = r_live - 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_TRD;
                end else if (r_rd.rot != '0) begin
                    w_we        = 1'b1;
                    w_wdata.rot = r_rd.rot - 1'b1;
                    w_wdata.seq = w_eseq;
                    n_wr[w_idx] = 1'b1;
                    n_i         = r_i + 1'b1;
                    n_state     = S_TRD;
                end else begin
                    n_fidx = IDX_W'(w_idx);
                    n_fseq = w_eseq;
                    if (r_rd.interval != '0) begin
                        n_delay   = r_rd.interval;
                        n_intv    = r_rd.interval;
                        n_pl_tick = 1'b1;
                        n_state   = S_PLA;
                    end else begin
                        w_we           = 1'b1;
                        w_wdata.seq    = w_eseq + 1'b1;
                        n_wr[w_idx]    = 1'b1;
                        n_valid[w_idx] = 1'b0;
                        n_canc[w_idx]  = 1'b0;
                        if (r_live != '0) n_live = r_live - 1'b1;
                        n_state = S_TFIRE;
                    end
                end
            end
            S_TARM: begin
                w_we        = 1'b1;
                w_wdata     = '{r_intv, r_rot, w_eseq, r_slot};
                n_wr[w_idx] = 1'b1;
                n_state     = S_TFIRE;
            end
            S_TFIRE: begin
                if (!r_pv || w_ofree) begin
                    if (r_pv) begin
                        n_ov  = 1'b1;
                        n_out = r_pend;
                    end
                    n_pv    = 1'b1;
                    n_pend  = '{KIND_FIRE, ST_OK, r_fidx, r_fseq, r_live, 1'b0};
                    n_i     = r_i + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_TEND: begin
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (w_ofree) begin
                    n_ov       = 1'b1;
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_pv       = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_REPLY: begin
                if (w_ofree) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_live  <= '0;
            r_valid <= '0;
            r_canc  <= '0;
            r_wr    <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_live  <= n_live;
            r_valid <= n_valid;
            r_canc  <= n_canc;
            r_wr    <= n_wr;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
        r_i       <= n_i;
        r_delay   <= n_delay;
        r_intv    <= n_intv;
        r_rot     <= n_rot;
        r_slot    <= n_slot;
        r_tslot   <= n_tslot;
        r_pl_tick <= n_pl_tick;
        r_hidx    <= n_hidx;
        r_hseq    <= n_hseq;
        r_res     <= n_res;
        r_fidx    <= n_fidx;
        r_fseq    <= n_fseq;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_out.live, r_out.seq, r_out.idx, r_out.status};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
endmodule
`default_nettype wire
